// File: rtl/pcs_pkg.sv
`timescale 1ns / 1ps

package pcs_pkg;

  // Fraction bits of the cosine measure.
  localparam int FRAC_BITS  = 16;
  localparam int MEASURE_W  = 17;
  localparam int Q_W        = FRAC_BITS + 1;
  localparam int COMP_W     = 13;
  localparam int SUM_W      = 28;
  localparam int PROD_W     = 2 * SUM_W;
  localparam int MSB_W      = 6;
  localparam int X_W        = 62;
  localparam int ROOT_W     = X_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int NUM_W      = ROOT_W + 1;
  localparam int K_W        = 5;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = Q_W;
  localparam int CHAIN_STAGES = SQRT_STEPS + DIV_STEPS;
  localparam int LUMA_W     = 12;
  localparam int LSUM_W     = 18;
  localparam int CHROMA_W   = 19;
  localparam int CFG_W      = 17;
  localparam int IDX_W      = 3;
  localparam int CMP_W      = 48;
  localparam int THR_SH     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DIFF_SH    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  // Chroma coefficients in Q.10 with the 128 offset.
  localparam int CHROMA_OFS = 131072;
  localparam int CB_R = 173;
  localparam int CB_G = 339;
  localparam int CR_G = 429;
  localparam int CR_B = 83;
  localparam int CHROMA_SH = 5;

  // Luma coefficients, result in Q8.4.
  localparam int LUMA_R   = 306;
  localparam int LUMA_G   = 601;
  localparam int LUMA_B   = 117;
  localparam int LUMA_RND = 32;

  localparam int ANGLE_THR_RST = 7;
  localparam int LUMA_THR_RST  = 400;

  typedef enum logic [1:0] {
    MODE_CBCR = 2'd0,
    MODE_RGB  = 2'd1,
    MODE_LUMA = 2'd2
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SEED_BLUE       = 3'd0,
    REG_SEED_GREEN      = 3'd1,
    REG_SEED_RED        = 3'd2,
    REG_SEED_LUMA       = 3'd3,
    REG_ANGLE_THRESHOLD = 3'd4,
    REG_LUMA_THRESHOLD  = 3'd5
  } reg_idx_t;

  // Payload that travels through the root and divide stages.
  typedef struct packed {
    logic [1:0]        mode;
    logic              degen;
    logic [LUMA_W-1:0] luma_diff;
    logic [X_W-1:0]    x;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [NUM_W-1:0]  num;
    logic [Q_W-1:0]    quo;
  } work_t;

  // Cb and Cr of one color, truncated to Q.5.
  function automatic logic [2*COMP_W-1:0] chroma(input logic [7:0] b,
                                                 input logic [7:0] g,
                                                 input logic [7:0] r);
    logic [CHROMA_W-1:0] cb;
    logic [CHROMA_W-1:0] cr;
    cb = CHROMA_W'(CHROMA_OFS) + (CHROMA_W'(b) << 9)
         - CHROMA_W'(CB_R) * CHROMA_W'(r) - CHROMA_W'(CB_G) * CHROMA_W'(g);
    cr = CHROMA_W'(CHROMA_OFS) + (CHROMA_W'(r) << 9)
         - CHROMA_W'(CR_G) * CHROMA_W'(g) - CHROMA_W'(CR_B) * CHROMA_W'(b);
    return {cb[CHROMA_SH +: COMP_W], cr[CHROMA_SH +: COMP_W]};
  endfunction

  // One digit of the restoring square root, two radicand bits per step.
  function automatic work_t sqrt_step(input work_t w);
    work_t            o;
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    o     = w;
    sh    = {w.rem[REM_W-3:0], w.x[X_W-1 -: 2]};
    trial = {1'b0, w.root, 2'b01};
    o.x   = {w.x[X_W-3:0], 2'b00};
    if (sh >= trial) begin
      o.rem  = sh - trial;
      o.root = {w.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = sh;
      o.root = {w.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit of the restoring divide by the root.
  function automatic work_t div_step(input work_t w);
    work_t          o;
    logic [NUM_W:0] t;
    logic [NUM_W:0] d;
    o = w;
    t = {w.num, 1'b0};
    d = {2'b00, w.root};
    if (t >= d) begin
      o.num = NUM_W'(t - d);
      o.quo = {w.quo[Q_W-2:0], 1'b1};
    end else begin
      o.num = t[NUM_W-1:0];
      o.quo = {w.quo[Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// File: rtl/pcs_pixel_if.sv
`timescale 1ns / 1ps

interface pcs_pixel_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] pixel_blue;
  logic [7:0] pixel_green;
  logic [7:0] pixel_red;

  modport source(output valid, mode, pixel_blue, pixel_green, pixel_red, input ready);
  modport sink(input valid, mode, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

// File: rtl/pcs_result_if.sv
`timescale 1ns / 1ps

interface pcs_result_if;
  logic        valid;
  logic        ready;
  logic [16:0] measure;
  logic        close;
  logic        degenerate;

  modport source(output valid, measure, close, degenerate, input ready);
  modport sink(input valid, measure, close, degenerate, output ready);
endinterface

// File: rtl/pcs_root_div.sv
`timescale 1ns / 1ps

// Square root stages followed by divide stages, one step per stage.
module pcs_root_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  pcs_pkg::work_t in_work,
  output logic           out_valid,
  output pcs_pkg::work_t out_work
);

  logic [pcs_pkg::CHAIN_STAGES:0] vld;
  pcs_pkg::work_t                 stg [pcs_pkg::CHAIN_STAGES+1];

  assign vld[0] = in_valid;
  assign stg[0] = in_work;

  for (genvar j = 0; j < pcs_pkg::CHAIN_STAGES; j++) begin : g_stage
    // Valid bit of this stage.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= vld[j];
      end
    end

    // Root digit in the first stages, quotient bit in the rest.
    if (j < pcs_pkg::SQRT_STEPS) begin : g_sqrt
      always_ff @(posedge clk) begin
        if (adv) begin
          stg[j+1] <= pcs_pkg::sqrt_step(stg[j]);
        end
      end
    end else begin : g_div
      always_ff @(posedge clk) begin
        if (adv) begin
          stg[j+1] <= pcs_pkg::div_step(stg[j]);
        end
      end
    end
  end

  assign out_valid = vld[pcs_pkg::CHAIN_STAGES];
  assign out_work  = stg[pcs_pkg::CHAIN_STAGES];

endmodule

// File: rtl/pixel_color_similarity.sv
`timescale 1ns / 1ps

// Compares each pixel on the pixel channel with the seed color held in the
// configuration registers and sends one result per pixel on the result channel.
// The mode of a pixel selects the CbCr cosine, the RGB cosine or the luma
// difference; close and degenerate come with the measure.
// Configuration registers are written through cfg_write, cfg_index and cfg_data;
// the user must write them only while no pixel is in flight, as the block does
// not enforce it. Writes to unused indexes are ignored. One pixel is taken per
// cycle unless a result waits on a stalled receiver. A pixel passes five front
// stages (input, vectors, products, length product, normalize), 31 square root
// stages, 17 divide stages (one digit per stage) and the output register.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// pixel.ready drops; nothing is lost or repeated, and it resumes at full rate.
module pixel_color_similarity (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [pcs_pkg::IDX_W-1:0] cfg_index,
  input  logic [pcs_pkg::CFG_W-1:0] cfg_data,
  pcs_pixel_if.sink                 pixel,
  pcs_result_if.source              result
);

  localparam int CW = pcs_pkg::COMP_W;
  localparam int SW = pcs_pkg::SUM_W;
  localparam int LW = pcs_pkg::LUMA_W;
  localparam int QW = pcs_pkg::Q_W;
  localparam logic [QW-1:0] ONE = QW'(1) << pcs_pkg::FRAC_BITS;

  // Configuration registers.
  logic [7:0]                seed_blue;
  logic [7:0]                seed_green;
  logic [7:0]                seed_red;
  logic [LW-1:0]             seed_luma;
  logic [pcs_pkg::CFG_W-1:0] angle_threshold;
  logic [LW-1:0]             luma_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_blue       <= '0;
      seed_green      <= '0;
      seed_red        <= '0;
      seed_luma       <= '0;
      angle_threshold <= pcs_pkg::CFG_W'(pcs_pkg::ANGLE_THR_RST);
      luma_threshold  <= LW'(pcs_pkg::LUMA_THR_RST);
    end else if (cfg_write) begin
      unique case (cfg_index)
        pcs_pkg::REG_SEED_BLUE:       seed_blue       <= cfg_data[7:0];
        pcs_pkg::REG_SEED_GREEN:      seed_green      <= cfg_data[7:0];
        pcs_pkg::REG_SEED_RED:        seed_red        <= cfg_data[7:0];
        pcs_pkg::REG_SEED_LUMA:       seed_luma       <= cfg_data[LW-1:0];
        pcs_pkg::REG_ANGLE_THRESHOLD: angle_threshold <= cfg_data;
        pcs_pkg::REG_LUMA_THRESHOLD:  luma_threshold  <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless a result waits on a stalled receiver.
  logic adv;
  logic out_valid;
  assign adv         = !out_valid || result.ready;
  assign pixel.ready = adv;

  // Stage 1: input register.
  logic       s1_valid;
  logic [1:0] s1_mode;
  logic [7:0] s1_blue;
  logic [7:0] s1_green;
  logic [7:0] s1_red;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode  <= pixel.mode;
      s1_blue  <= pixel.pixel_blue;
      s1_green <= pixel.pixel_green;
      s1_red   <= pixel.pixel_red;
    end
  end

  // Vector selection: chroma pair or the three color channels; luma of the pixel.
  logic [2*CW-1:0]             seed_cc;
  logic [2*CW-1:0]             pix_cc;
  logic [CW-1:0]               va [3];
  logic [CW-1:0]               vb [3];
  logic [pcs_pkg::LSUM_W-1:0]  lsum;

  assign seed_cc = pcs_pkg::chroma(seed_blue, seed_green, seed_red);
  assign pix_cc  = pcs_pkg::chroma(s1_blue, s1_green, s1_red);
  assign lsum    = pcs_pkg::LSUM_W'(pcs_pkg::LUMA_R) * pcs_pkg::LSUM_W'(s1_red)
                 + pcs_pkg::LSUM_W'(pcs_pkg::LUMA_G) * pcs_pkg::LSUM_W'(s1_green)
                 + pcs_pkg::LSUM_W'(pcs_pkg::LUMA_B) * pcs_pkg::LSUM_W'(s1_blue)
                 + pcs_pkg::LSUM_W'(pcs_pkg::LUMA_RND);

  always_comb begin
    case (pcs_pkg::mode_t'(s1_mode))
      pcs_pkg::MODE_CBCR: begin
        va[0] = seed_cc[CW +: CW];
        va[1] = seed_cc[0 +: CW];
        va[2] = '0;
        vb[0] = pix_cc[CW +: CW];
        vb[1] = pix_cc[0 +: CW];
        vb[2] = '0;
      end
      pcs_pkg::MODE_RGB: begin
        va[0] = CW'(seed_blue);
        va[1] = CW'(seed_green);
        va[2] = CW'(seed_red);
        vb[0] = CW'(s1_blue);
        vb[1] = CW'(s1_green);
        vb[2] = CW'(s1_red);
      end
      default: begin
        va[0] = '0;
        va[1] = '0;
        va[2] = '0;
        vb[0] = '0;
        vb[1] = '0;
        vb[2] = '0;
      end
    endcase
  end

  // Stage 2: vectors and pixel luma.
  logic          s2_valid;
  logic [1:0]    s2_mode;
  logic [CW-1:0] s2_a [3];
  logic [CW-1:0] s2_b [3];
  logic [LW-1:0] s2_luma;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mode <= s1_mode;
      s2_a    <= va;
      s2_b    <= vb;
      s2_luma <= lsum[pcs_pkg::LSUM_W-1 -: LW];
    end
  end

  // Dot product, squared lengths and luma difference.
  logic [SW-1:0] dot;
  logic [SW-1:0] len_a;
  logic [SW-1:0] len_b;
  logic [LW-1:0] ldiff;

  assign dot   = SW'(s2_a[0]) * SW'(s2_b[0]) + SW'(s2_a[1]) * SW'(s2_b[1])
               + SW'(s2_a[2]) * SW'(s2_b[2]);
  assign len_a = SW'(s2_a[0]) * SW'(s2_a[0]) + SW'(s2_a[1]) * SW'(s2_a[1])
               + SW'(s2_a[2]) * SW'(s2_a[2]);
  assign len_b = SW'(s2_b[0]) * SW'(s2_b[0]) + SW'(s2_b[1]) * SW'(s2_b[1])
               + SW'(s2_b[2]) * SW'(s2_b[2]);
  assign ldiff = (seed_luma >= s2_luma) ? seed_luma - s2_luma : s2_luma - seed_luma;

  // Stage 3: products.
  logic          s3_valid;
  logic [1:0]    s3_mode;
  logic [SW-1:0] s3_dot;
  logic [SW-1:0] s3_len_a;
  logic [SW-1:0] s3_len_b;
  logic [LW-1:0] s3_ldiff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_mode  <= s2_mode;
      s3_dot   <= dot;
      s3_len_a <= len_a;
      s3_len_b <= len_b;
      s3_ldiff <= ldiff;
    end
  end

  // Stage 4: product of the squared lengths.
  logic                        s4_valid;
  logic [1:0]                  s4_mode;
  logic [SW-1:0]               s4_dot;
  logic [pcs_pkg::PROD_W-1:0]  s4_prod;
  logic                        s4_degen;
  logic [LW-1:0]               s4_ldiff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_mode  <= s3_mode;
      s4_dot   <= s3_dot;
      s4_prod  <= pcs_pkg::PROD_W'(s3_len_a) * pcs_pkg::PROD_W'(s3_len_b);
      s4_degen <= (s3_len_a == '0) || (s3_len_b == '0);
      s4_ldiff <= s3_ldiff;
    end
  end

  // Leading one of the product sets the normalizing shift.
  logic [pcs_pkg::MSB_W-1:0] msb;
  logic [pcs_pkg::MSB_W-1:0] kk;

  always_comb begin
    msb = '0;
    for (int i = 0; i < pcs_pkg::PROD_W; i++) begin
      if (s4_prod[i]) begin
        msb = pcs_pkg::MSB_W'(i);
      end
    end
  end

  assign kk = (pcs_pkg::MSB_W'(pcs_pkg::X_W - 1) - msb) >> 1;

  // Stage 5: normalizing shift.
  logic                        s5_valid;
  logic [1:0]                  s5_mode;
  logic [SW-1:0]               s5_dot;
  logic [pcs_pkg::PROD_W-1:0]  s5_prod;
  logic                        s5_degen;
  logic [LW-1:0]               s5_ldiff;
  logic [pcs_pkg::K_W-1:0]     s5_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_mode  <= s4_mode;
      s5_dot   <= s4_dot;
      s5_prod  <= s4_prod;
      s5_degen <= s4_degen;
      s5_ldiff <= s4_ldiff;
      s5_k     <= kk[pcs_pkg::K_W-1:0];
    end
  end

  // Radicand and first partial remainder of the divide.
  logic [63:0]    x_wide;
  logic [63:0]    num_wide;
  pcs_pkg::work_t chain_in;

  assign x_wide   = 64'(s5_prod) << {s5_k, 1'b0};
  assign num_wide = 64'(s5_dot) << (s5_k - pcs_pkg::K_W'(1));

  always_comb begin
    chain_in           = '0;
    chain_in.mode      = s5_mode;
    chain_in.degen     = s5_degen;
    chain_in.luma_diff = s5_ldiff;
    chain_in.x         = x_wide[pcs_pkg::X_W-1:0];
    chain_in.num       = num_wide[pcs_pkg::NUM_W-1:0];
  end

  logic           chain_valid;
  pcs_pkg::work_t chain_out;

  pcs_root_div u_root_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s5_valid),
    .in_work   (chain_in),
    .out_valid (chain_valid),
    .out_work  (chain_out)
  );

  // Clamp the cosine and compare against the selected threshold.
  logic [QW-1:0]                 q_clamp;
  logic [QW-1:0]                 q_diff;
  logic [pcs_pkg::CMP_W-1:0]     diff_cmp;
  logic [pcs_pkg::CMP_W-1:0]     thr_cmp;
  logic [pcs_pkg::MEASURE_W-1:0] measure_next;
  logic                          close_next;
  logic                          degen_next;

  assign q_clamp  = (chain_out.quo > ONE) ? ONE : chain_out.quo;
  assign q_diff   = ONE - q_clamp;
  assign diff_cmp = pcs_pkg::CMP_W'(q_diff) << pcs_pkg::DIFF_SH;
  assign thr_cmp  = pcs_pkg::CMP_W'(angle_threshold) << pcs_pkg::THR_SH;

  always_comb begin
    case (pcs_pkg::mode_t'(chain_out.mode)) inside
      pcs_pkg::MODE_CBCR, pcs_pkg::MODE_RGB: begin
        if (chain_out.degen) begin
          measure_next = '0;
          close_next   = 1'b0;
          degen_next   = 1'b1;
        end else begin
          measure_next = pcs_pkg::MEASURE_W'(q_clamp);
          close_next   = diff_cmp < thr_cmp;
          degen_next   = 1'b0;
        end
      end
      pcs_pkg::MODE_LUMA: begin
        measure_next = pcs_pkg::MEASURE_W'(chain_out.luma_diff);
        close_next   = chain_out.luma_diff < luma_threshold;
        degen_next   = 1'b0;
      end
      default: begin
        measure_next = '0;
        close_next   = 1'b0;
        degen_next   = 1'b0;
      end
    endcase
  end

  // Output register.
  logic [1:0]                    out_mode;
  logic [pcs_pkg::MEASURE_W-1:0] out_measure;
  logic                          out_close;
  logic                          out_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= chain_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mode    <= chain_out.mode;
      out_measure <= measure_next;
      out_close   <= close_next;
      out_degen   <= degen_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.measure    = out_measure;
  assign result.close      = out_close;
  assign result.degenerate = out_degen;

  // A degenerate result carries a zero measure and no close flag.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_degen |-> (out_measure == '0) && !out_close)
    else $error("degenerate result with nonzero measure or close");

  // Cosine results never exceed one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_mode == pcs_pkg::MODE_CBCR || out_mode == pcs_pkg::MODE_RGB)
    |-> pcs_pkg::MEASURE_W'(out_measure) <= pcs_pkg::MEASURE_W'(ONE))
    else $error("cosine measure above one");

  // Luma and undefined modes are never degenerate.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !(out_mode == pcs_pkg::MODE_CBCR || out_mode == pcs_pkg::MODE_RGB)
    |-> !out_degen)
    else $error("degenerate flag outside cosine modes");

  // Chroma vectors always have length, so mode 0 is never degenerate.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_mode == pcs_pkg::MODE_CBCR) |-> !out_degen)
    else $error("degenerate chroma vector");

  // A stalled result stays in place on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> out_valid && $stable(out_measure) && $stable(out_mode))
    else $error("output register changed during a stall");

endmodule
